FILE: sv/mhs_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the multivariate hypergeometric sampler.
// No dependencies; used by the RAM-backed sampler top level.
package mhs_pkg;

  localparam int MAX_BINS   = 64;
  localparam int COUNT_BITS = 24;
  localparam int BIN_W      = $clog2(MAX_BINS);
  localparam int NXT_W      = BIN_W + 1;
  localparam int BIU_W      = 7;
  localparam int CFG_W      = 24;

  // Request types.
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_DRAW = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RANGE     = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_LIMIT     = 3'd3;
  localparam logic [2:0] ST_LOAD_ERR  = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_BINS_IN_USE = 1'b0;
  localparam logic CFG_DRAW_LIMIT  = 1'b1;

  localparam logic [BIU_W-1:0]      BIU_RESET  = BIU_W'(64);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

endpackage

FILE: sv/multivariate_hypergeometric_sampler_unit.sv
`timescale 1ns / 1ps
// Top level of the multivariate hypergeometric sampler.
// Depends on mhs_pkg and two mhs_ram instances (cumulative counts, bin tallies).

// One item is processed at a time; a new item is taken as soon as the previous
// one has placed its result in the output register, even if that result has not
// yet been taken. Loads, reads and refused draws pass through S_TRD, S_TALLY and
// S_OUT. An accepted draw first runs a binary search over the cumulative-count
// RAM (one read plus one compare per step, over the bins loaded), then visits each
// cumulative entry from the chosen bin up to the last loaded bin for the
// read-decrement-write walk, then passes through S_TRD, S_TALLY and S_OUT.
// The single read port of the cumulative-count RAM makes the search and walk serial.
// Tallies are cleared at once by a load at bin 0 through per-bin valid flags,
// so there is no clearing pass after reset.
module multivariate_hypergeometric_sampler_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_req_type,
  input  logic [5:0]                      in_bin_index,
  input  logic [mhs_pkg::COUNT_BITS-1:0]  in_bin_count,
  input  logic [mhs_pkg::COUNT_BITS-1:0]  in_rand_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_status,
  output logic [5:0]                      out_chosen_bin,
  output logic [mhs_pkg::COUNT_BITS-1:0]  out_tally_value,
  output logic [mhs_pkg::COUNT_BITS-1:0]  out_remaining,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [mhs_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int CB = mhs_pkg::COUNT_BITS;
  localparam int BW = mhs_pkg::BIN_W;
  localparam int NW = mhs_pkg::NXT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_SCMP  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_TRD   = 3'd4;
  localparam logic [2:0] S_TALLY = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // Control state.
  logic [2:0]                    state_r, state_nxt;
  logic [CB-1:0]                 pop_r, pop_nxt;
  logic [CB-1:0]                 draws_r, draws_nxt;
  logic [NW-1:0]                 next_r, next_nxt;
  logic [mhs_pkg::BIU_W-1:0]     biu_r, biu_nxt;
  logic [CB-1:0]                 dlim_r, dlim_nxt;
  logic [mhs_pkg::MAX_BINS-1:0]  tval_r, tval_nxt;
  logic                          wb_vld_r, wb_vld_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // Per-item working registers.
  logic [CB-1:0] rand_r, rand_nxt;
  logic [BW-1:0] lo_r, lo_nxt;
  logic [BW-1:0] hi_r, hi_nxt;
  logic [BW-1:0] top_r, top_nxt;
  logic [BW-1:0] ptr_r, ptr_nxt;
  logic [BW-1:0] wb_addr_r, wb_addr_nxt;
  logic [2:0]    res_status_r, res_status_nxt;
  logic [BW-1:0] res_bin_r, res_bin_nxt;
  logic          res_zero_r, res_zero_nxt;
  logic          res_inc_r, res_inc_nxt;
  logic [CB-1:0] res_tally_r, res_tally_nxt;

  // Output register payload.
  logic [2:0]    out_status_r, out_status_nxt;
  logic [5:0]    out_bin_r, out_bin_nxt;
  logic [CB-1:0] out_tally_r, out_tally_nxt;
  logic [CB-1:0] out_rem_r, out_rem_nxt;

  // RAM ports.
  logic          cum_we;
  logic [BW-1:0] cum_waddr, cum_raddr;
  logic [CB-1:0] cum_wdata, cum_rdata;
  logic          tal_we;
  logic [CB-1:0] tal_wdata, tal_rdata;

  // Request decode helpers.
  logic          accept;
  logic [NW-1:0] active_bins;
  logic [NW-1:0] idx_ext;
  logic [BW-1:0] idx;
  logic          idx_zero;
  logic [CB-1:0] load_base;
  logic [CB:0]   load_sum;
  logic          load_ok;
  logic [BW:0]   mid_sum;
  logic [BW-1:0] mid;
  logic          ge_r;
  logic [CB-1:0] tally_old;
  logic [CB-1:0] tally_inc;

  mhs_ram #(.WIDTH(CB), .DEPTH(mhs_pkg::MAX_BINS)) u_cum_ram (
    .clk   (clk),
    .we    (cum_we),
    .waddr (cum_waddr),
    .wdata (cum_wdata),
    .raddr (cum_raddr),
    .rdata (cum_rdata)
  );

  mhs_ram #(.WIDTH(CB), .DEPTH(mhs_pkg::MAX_BINS)) u_tally_ram (
    .clk   (clk),
    .we    (tal_we),
    .waddr (res_bin_r),
    .wdata (tal_wdata),
    .raddr (res_bin_r),
    .rdata (tal_rdata)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign accept          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_chosen_bin  = out_bin_r;
  assign out_tally_value = out_tally_r;
  assign out_remaining   = out_rem_r;

  assign idx      = BW'(in_bin_index);
  assign idx_ext  = NW'(in_bin_index);
  assign idx_zero = (in_bin_index == 6'd0);

  // Zero acts as one bin; anything above the store size acts as the store size.
  always_comb begin
    if (biu_r == '0) begin
      active_bins = NW'(1);
    end else if (NW'(biu_r) > NW'(mhs_pkg::MAX_BINS)) begin
      active_bins = NW'(mhs_pkg::MAX_BINS);
    end else begin
      active_bins = NW'(biu_r);
    end
  end

  assign load_base = idx_zero ? '0 : pop_r;
  assign load_sum  = {1'b0, load_base} + {1'b0, in_bin_count};
  assign load_ok   = (idx_ext < active_bins) && (idx_ext < NW'(mhs_pkg::MAX_BINS)) &&
                     (idx_zero || (idx_ext == next_r)) && !load_sum[CB];

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[BW:1];
  assign ge_r    = (cum_rdata >= rand_r);

  assign tally_old = tval_r[res_bin_r] ? tal_rdata : '0;
  assign tally_inc = tally_old + CB'(1);
  assign tal_we    = (state_r == S_TALLY) && res_inc_r;
  assign tal_wdata = tally_inc;

  // The walk writes back each entry in the cycle after its read.
  always_comb begin
    cum_we    = wb_vld_r || (accept && (in_req_type == mhs_pkg::REQ_LOAD) && load_ok);
    cum_waddr = wb_vld_r ? wb_addr_r : idx;
    if (wb_vld_r) begin
      cum_wdata = (cum_rdata != '0) ? (cum_rdata - CB'(1)) : cum_rdata;
    end else begin
      cum_wdata = load_sum[CB-1:0];
    end
    cum_raddr = (state_r == S_WALK) ? ptr_r : mid;
  end

  always_comb begin
    state_nxt      = state_r;
    pop_nxt        = pop_r;
    draws_nxt      = draws_r;
    next_nxt       = next_r;
    biu_nxt        = biu_r;
    dlim_nxt       = dlim_r;
    tval_nxt       = tval_r;
    wb_vld_nxt     = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    rand_nxt       = rand_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    top_nxt        = top_r;
    ptr_nxt        = ptr_r;
    wb_addr_nxt    = wb_addr_r;
    res_status_nxt = res_status_r;
    res_bin_nxt    = res_bin_r;
    res_zero_nxt   = res_zero_r;
    res_inc_nxt    = res_inc_r;
    res_tally_nxt  = res_tally_r;
    out_status_nxt = out_status_r;
    out_bin_nxt    = out_bin_r;
    out_tally_nxt  = out_tally_r;
    out_rem_nxt    = out_rem_r;

    if (cfg_we) begin
      unique case (cfg_index)
        mhs_pkg::CFG_BINS_IN_USE: biu_nxt  = cfg_wdata[mhs_pkg::BIU_W-1:0];
        mhs_pkg::CFG_DRAW_LIMIT:  dlim_nxt = cfg_wdata[CB-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          rand_nxt     = in_rand_value;
          res_bin_nxt  = idx;
          res_zero_nxt = 1'b0;
          res_inc_nxt  = 1'b0;
          state_nxt    = S_TRD;
          unique case (in_req_type)
            mhs_pkg::REQ_LOAD: begin
              if (load_ok) begin
                res_status_nxt = mhs_pkg::ST_OK;
                pop_nxt        = load_sum[CB-1:0];
                next_nxt       = idx_ext + NW'(1);
                if (idx_zero) begin
                  tval_nxt  = '0;
                  draws_nxt = '0;
                end
              end else begin
                res_status_nxt = mhs_pkg::ST_LOAD_ERR;
              end
            end
            mhs_pkg::REQ_DRAW: begin
              res_bin_nxt  = '0;
              res_zero_nxt = 1'b1;
              priority if (pop_r == '0 || next_r == '0) begin
                res_status_nxt = mhs_pkg::ST_EMPTY;
              end else if (draws_r >= dlim_r) begin
                res_status_nxt = mhs_pkg::ST_LIMIT;
              end else if (in_rand_value == '0 || in_rand_value > pop_r) begin
                res_status_nxt = mhs_pkg::ST_RANGE;
              end else begin
                // The last loaded cumulative count equals the population left,
                // so the search over bins 0..n-1 always finds a bin.
                res_status_nxt = mhs_pkg::ST_OK;
                res_zero_nxt   = 1'b0;
                res_inc_nxt    = 1'b1;
                lo_nxt         = '0;
                hi_nxt         = BW'(next_r - NW'(1));
                top_nxt        = BW'(next_r - NW'(1));
                ptr_nxt        = '0;
                state_nxt      = (next_r == NW'(1)) ? S_WALK : S_SRCH;
              end
            end
            mhs_pkg::REQ_READ: begin
              res_status_nxt = mhs_pkg::ST_OK;
            end
            default: begin
              res_status_nxt = mhs_pkg::ST_LOAD_ERR;
              res_zero_nxt   = 1'b1;
            end
          endcase
        end
      end

      S_SRCH: begin
        state_nxt = S_SCMP;
      end

      S_SCMP: begin
        if (ge_r) begin
          hi_nxt = mid;
        end else begin
          lo_nxt = mid + BW'(1);
        end
        if ((ge_r ? lo_r : (mid + BW'(1))) < (ge_r ? mid : hi_r)) begin
          state_nxt = S_SRCH;
        end else begin
          ptr_nxt     = ge_r ? mid : hi_r;
          res_bin_nxt = ge_r ? mid : hi_r;
          state_nxt   = S_WALK;
        end
      end

      S_WALK: begin
        wb_vld_nxt  = 1'b1;
        wb_addr_nxt = ptr_r;
        if (ptr_r == top_r) begin
          state_nxt = S_TRD;
        end else begin
          ptr_nxt = ptr_r + BW'(1);
        end
      end

      S_TRD: begin
        state_nxt = S_TALLY;
      end

      S_TALLY: begin
        if (res_zero_r) begin
          res_tally_nxt = '0;
        end else if (res_inc_r) begin
          res_tally_nxt        = tally_inc;
          tval_nxt[res_bin_r]  = 1'b1;
          pop_nxt              = pop_r - CB'(1);
          draws_nxt            = draws_r + CB'(1);
        end else begin
          res_tally_nxt = tally_old;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_bin_nxt    = 6'(res_bin_r);
          out_tally_nxt  = res_tally_r;
          out_rem_nxt    = pop_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pop_r       <= '0;
      draws_r     <= '0;
      next_r      <= '0;
      biu_r       <= mhs_pkg::BIU_RESET;
      dlim_r      <= mhs_pkg::COUNT_MAX;
      tval_r      <= '0;
      wb_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pop_r       <= pop_nxt;
      draws_r     <= draws_nxt;
      next_r      <= next_nxt;
      biu_r       <= biu_nxt;
      dlim_r      <= dlim_nxt;
      tval_r      <= tval_nxt;
      wb_vld_r    <= wb_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rand_r       <= rand_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    top_r        <= top_nxt;
    ptr_r        <= ptr_nxt;
    wb_addr_r    <= wb_addr_nxt;
    res_status_r <= res_status_nxt;
    res_bin_r    <= res_bin_nxt;
    res_zero_r   <= res_zero_nxt;
    res_inc_r    <= res_inc_nxt;
    res_tally_r  <= res_tally_nxt;
    out_status_r <= out_status_nxt;
    out_bin_r    <= out_bin_nxt;
    out_tally_r  <= out_tally_nxt;
    out_rem_r    <= out_rem_nxt;
  end

endmodule

FILE: sv/mhs_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module mhs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/multivariate_hypergeometric_sampler_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for multivariate_hypergeometric_sampler_unit: a local predictor
// of bin loads, draws and tally reads checks every result item in order.
// Depends on mhs_pkg and the sampler top level; reads no files.
module multivariate_hypergeometric_sampler_unit_test;
  import mhs_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [2:0]            status;
    logic [5:0]            chosen_bin;
    logic [COUNT_BITS-1:0] tally_value;
    logic [COUNT_BITS-1:0] remaining;
  } draw_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             in_req_type;
  logic [5:0]             in_bin_index;
  logic [COUNT_BITS-1:0]  in_bin_count;
  logic [COUNT_BITS-1:0]  in_rand_value;
  logic                   out_valid;
  logic                   out_ready;
  logic [2:0]             out_status;
  logic [5:0]             out_chosen_bin;
  logic [COUNT_BITS-1:0]  out_tally_value;
  logic [COUNT_BITS-1:0]  out_remaining;
  logic                   cfg_we;
  logic                   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;

  // Predictor state and its copy of the configuration registers.
  logic [COUNT_BITS-1:0]  cum_model [MAX_BINS];
  logic [COUNT_BITS-1:0]  tally_model [MAX_BINS];
  logic [COUNT_BITS-1:0]  pop_model = '0;
  logic [COUNT_BITS-1:0]  draws_model = '0;
  logic [NXT_W-1:0]       next_bin_model = '0;
  logic [BIU_W-1:0]       bins_cfg = BIU_RESET;
  logic [COUNT_BITS-1:0]  limit_cfg = COUNT_MAX;

  draw_result_t           expected_results[$];
  int unsigned            items_sent = 0;
  int unsigned            fail_count = 0;
  bit                     no_idle = 1'b0;
  int unsigned            stall_request = 0;
  int unsigned            stall_left = 0;

  multivariate_hypergeometric_sampler_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_bin_index    (in_bin_index),
    .in_bin_count    (in_bin_count),
    .in_rand_value   (in_rand_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_chosen_bin  (out_chosen_bin),
    .out_tally_value (out_tally_value),
    .out_remaining   (out_remaining),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int unsigned live_bins();
    if (bins_cfg == 0) return 1;
    if (bins_cfg > MAX_BINS) return MAX_BINS;
    return bins_cfg;
  endfunction

  function automatic draw_result_t predict_sampler(logic [1:0] req, logic [5:0] idx,
                                                   logic [COUNT_BITS-1:0] cnt,
                                                   logic [COUNT_BITS-1:0] rnd);
    draw_result_t          res;
    logic [COUNT_BITS:0]   sum;
    int unsigned           n;
    int unsigned           pick;
    bit                    found;
    res.status      = ST_OK;
    res.chosen_bin  = idx;
    res.tally_value = '0;
    case (req)
      REQ_LOAD: begin
        sum = {1'b0, (idx == 0) ? '0 : pop_model} + {1'b0, cnt};
        if (idx >= live_bins() || (idx != 0 && idx != next_bin_model) || sum[COUNT_BITS]) begin
          res.status = ST_LOAD_ERR;
        end else begin
          // A load at bin 0 starts a new population.
          if (idx == 0) begin
            foreach (tally_model[i]) tally_model[i] = '0;
            draws_model = '0;
          end
          cum_model[idx] = sum[COUNT_BITS-1:0];
          pop_model      = sum[COUNT_BITS-1:0];
          next_bin_model = idx + 1;
        end
        res.tally_value = tally_model[idx];
      end
      REQ_DRAW: begin
        res.chosen_bin = '0;
        n = (next_bin_model > MAX_BINS) ? MAX_BINS : next_bin_model;
        found = 1'b0;
        pick = 0;
        if (pop_model == 0 || n == 0) begin
          res.status = ST_EMPTY;
        end else if (draws_model >= limit_cfg) begin
          res.status = ST_LIMIT;
        end else if (rnd == 0 || rnd > pop_model) begin
          res.status = ST_RANGE;
        end else begin
          // Smallest bin wins, so zero-count bins sharing a cumulative value are skipped.
          for (int j = 0; j < n; j++) begin
            if (!found && cum_model[j] >= rnd) begin
              pick = j;
              found = 1'b1;
            end
          end
          if (!found) begin
            res.status = ST_RANGE;
          end else begin
            tally_model[pick] = tally_model[pick] + 1'b1;
            for (int j = pick; j < n; j++) begin
              if (cum_model[j] != 0) cum_model[j] = cum_model[j] - 1'b1;
            end
            pop_model   = pop_model - 1'b1;
            draws_model = draws_model + 1'b1;
            res.chosen_bin  = pick[5:0];
            res.tally_value = tally_model[pick];
          end
        end
      end
      REQ_READ: begin
        res.tally_value = tally_model[idx];
      end
      default: begin
        res.status = ST_LOAD_ERR;
      end
    endcase
    res.remaining = pop_model;
    return res;
  endfunction

  function automatic void check_field(string name, logic [COUNT_BITS-1:0] want,
                                      logic [COUNT_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Result checker: every accepted result item is matched against the oldest prediction.
  always @(posedge clk) begin : check_results
    draw_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result item with no prediction waiting");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 24'(want.status), 24'(out_status));
        check_field("chosen_bin", 24'(want.chosen_bin), 24'(out_chosen_bin));
        check_field("tally_value", want.tally_value, out_tally_value);
        check_field("remaining", want.remaining, out_remaining);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 99) >= 38);
    end
  end

  task automatic send_item(logic [1:0] req, logic [5:0] idx, logic [COUNT_BITS-1:0] cnt,
                           logic [COUNT_BITS-1:0] rnd);
    while (!no_idle && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_bin_index  <= idx;
    in_bin_count  <= cnt;
    in_rand_value <= rnd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_sampler(req, idx, cnt, rnd));
    items_sent++;
  endtask

  task automatic send_draw(logic [COUNT_BITS-1:0] rnd);
    send_item(REQ_DRAW, 6'($urandom), 24'($urandom), rnd);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BINS_IN_USE) bins_cfg = value[BIU_W-1:0];
    else limit_cfg = value[COUNT_BITS-1:0];
    @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_draw(24'd1);                                  // nothing loaded yet
    send_item(REQ_READ, 6'd63, '0, '1);
    send_item(REQ_UNKNOWN, 6'd63, '1, '1);
    send_item(REQ_LOAD, 6'd5, 24'd9, '0);              // out of order
    send_item(REQ_LOAD, 6'd0, 24'd0, '0);
    send_draw(24'd1);                                  // empty population
    send_item(REQ_LOAD, 6'd0, 24'd3, '0);
    send_item(REQ_LOAD, 6'd1, 24'd0, '0);
    send_item(REQ_LOAD, 6'd2, 24'd0, '0);
    send_item(REQ_LOAD, 6'd3, 24'd2, '0);
    send_draw(24'd0);
    send_draw(24'd6);
    send_draw(24'd4);
    send_draw(24'd3);
    send_item(REQ_LOAD, 6'd4, COUNT_MAX, '0);          // overflows the total
    send_item(REQ_LOAD, 6'd4, COUNT_MAX - pop_model, '0);
    send_draw(COUNT_MAX);
    send_item(REQ_LOAD, 6'd2, 24'd1, '0);
    send_item(REQ_READ, 6'd3, '0, '0);
    send_item(REQ_READ, 6'd0, '0, '0);
    send_item(REQ_LOAD, 6'd0, COUNT_MAX, '1);          // restart clears every tally
    send_item(REQ_READ, 6'd3, '0, '0);
    send_draw(COUNT_MAX);
  endtask

  task automatic test_bins_in_use_limits();
    write_cfg(CFG_BINS_IN_USE, 24'd1);
    send_item(REQ_LOAD, 6'd0, 24'd10, '0);
    send_item(REQ_LOAD, 6'd1, 24'd5, '0);
    send_draw(24'd10);
    send_item(REQ_READ, 6'd0, '0, '0);
    write_cfg(CFG_BINS_IN_USE, 24'd0);
    send_item(REQ_LOAD, 6'd1, 24'd5, '0);
    send_item(REQ_LOAD, 6'd0, 24'd7, '0);
    write_cfg(CFG_BINS_IN_USE, 24'd127);
    for (int b = 0; b < MAX_BINS; b++) send_item(REQ_LOAD, 6'(b), 24'd1, '0);
    send_item(REQ_LOAD, 6'd63, 24'd1, '0);
    send_draw(24'(MAX_BINS));
    send_draw(24'd1);                                  // walks all 64 entries
    write_cfg(CFG_BINS_IN_USE, 24'd65);
    for (int b = 0; b < 4; b++) send_item(REQ_LOAD, 6'(b), 24'd3, '0);
    write_cfg(CFG_BINS_IN_USE, 24'(MAX_BINS));
    for (int b = 0; b < 8; b++) send_item(REQ_LOAD, 6'(b), 24'd2, '0);
    // Fewer bins in use later must not shrink the draw search.
    write_cfg(CFG_BINS_IN_USE, 24'd2);
    send_draw(24'd16);
    send_item(REQ_LOAD, 6'd8, 24'd2, '0);
    send_item(REQ_READ, 6'd7, '0, '0);
    write_cfg(CFG_BINS_IN_USE, 24'(MAX_BINS));
  endtask

  task automatic test_draw_limit();
    write_cfg(CFG_DRAW_LIMIT, 24'd0);
    send_item(REQ_LOAD, 6'd0, 24'd5, '0);
    send_draw(24'd1);
    write_cfg(CFG_DRAW_LIMIT, 24'd2);
    repeat (3) send_draw(24'd1);
    send_item(REQ_LOAD, 6'd0, 24'd5, '0);
    send_draw(24'd5);
    write_cfg(CFG_DRAW_LIMIT, COUNT_MAX);
    send_draw(24'd2);
  endtask

  task automatic test_output_backpressure();
    write_cfg(CFG_DRAW_LIMIT, COUNT_MAX);
    no_idle = 1'b1;
    stall_request = 300;
    send_item(REQ_LOAD, 6'd0, 24'd20, '0);
    send_item(REQ_LOAD, 6'd1, 24'd20, '0);
    repeat (12) begin
      if ($urandom_range(0, 3) == 0) send_item(REQ_READ, 6'($urandom_range(0, 1)), '0, '0);
      else send_draw(24'($urandom_range(1, pop_model)));
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_sampling(int unsigned quota);
    int unsigned first;
    int unsigned episode;
    int unsigned live;
    int unsigned nbins;
    int unsigned headroom;
    logic [COUNT_BITS-1:0] cnt;
    first = items_sent;
    episode = 0;
    while (items_sent - first < quota) begin
      episode++;
      no_idle = (episode >= 4 && episode <= 8);
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0: write_cfg(CFG_BINS_IN_USE, 24'($urandom_range(0, 127)));
          1: write_cfg(CFG_BINS_IN_USE, 24'(MAX_BINS));
          2: write_cfg(CFG_BINS_IN_USE, 24'($urandom_range(1, 12)));
          3: write_cfg(CFG_DRAW_LIMIT, 24'($urandom_range(0, 30)));
          default: write_cfg(CFG_DRAW_LIMIT, COUNT_MAX);
        endcase
      end
      live = live_bins();
      if ($urandom_range(0, 7) == 0) nbins = live;
      else nbins = $urandom_range(1, (live < 8) ? live : 8);
      for (int b = 0; b < nbins; b++) begin
        headroom = COUNT_MAX - ((b == 0) ? 0 : pop_model);
        case ($urandom_range(0, 9))
          0: cnt = '0;
          1: cnt = 24'($urandom_range(0, headroom));
          2: cnt = 24'($urandom);                   // may overflow the total
          default: cnt = 24'($urandom_range(0, (headroom < 40) ? headroom : 40));
        endcase
        send_item(REQ_LOAD, 6'(b), cnt, 24'($urandom));
      end
      repeat ($urandom_range(4, 30)) begin
        case ($urandom_range(0, 15))
          0: send_item(REQ_READ, 6'($urandom), 24'($urandom), 24'($urandom));
          1: send_item(2'($urandom), 6'($urandom), 24'($urandom), 24'($urandom));
          2: send_draw(24'($urandom));
          3: begin
            case ($urandom_range(0, 2))
              0: send_draw('0);
              1: send_draw(pop_model);
              default: send_draw(pop_model + 1'b1);
            endcase
          end
          default: send_draw(24'($urandom_range(1, (pop_model == 0) ? 1 : pop_model)));
        endcase
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= REQ_LOAD;
    in_bin_index  <= '0;
    in_bin_count  <= '0;
    in_rand_value <= '0;
    out_ready     <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_BINS_IN_USE;
    cfg_wdata     <= '0;
    foreach (tally_model[i]) tally_model[i] = '0;
    foreach (cum_model[i]) cum_model[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_bins_in_use_limits();
    test_draw_limit();
    test_output_backpressure();
    test_random_sampling(820);
    wait_idle();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
